// ----- hw/rtl/vector_turtle_perspective_engine_assert.svh -----
// Assertion macros used by the vector turtle engine top level.
`ifndef VECTOR_TURTLE_PERSPECTIVE_ENGINE_ASSERT_SVH
`define VECTOR_TURTLE_PERSPECTIVE_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define VTPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define VTPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/vtpe_pkg.sv -----
// Shared types, constants and sizes of the vector turtle engine.
`default_nettype none
package vtpe_pkg;

  localparam int STACK_DEPTH = 127;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam int ORI_W = 18;
  localparam int POS_W = 32;
  localparam int SCR_W = 16;
  localparam int ROW_W = 9 * ORI_W + 3 * POS_W + 2 * SCR_W;

  localparam int IN_W  = 136;
  localparam int OUT_W = 64;
  localparam int CFG_W = 16;

  // Sequencer step indices
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] ROT_LAST  = 5'd23;
  localparam logic [CNT_W-1:0] XLT_LAST  = 5'd17;
  localparam logic [CNT_W-1:0] PROJ_MUL  = 5'd0;
  localparam logic [CNT_W-1:0] PROJ_LOAD = 5'd1;
  localparam logic [CNT_W-1:0] PROJ_LAST = 5'd18;

  typedef enum logic [3:0] {
    K_ROTX    = 4'd0,
    K_ROTY    = 4'd1,
    K_ROTZ    = 4'd2,
    K_MOVE_BY = 4'd3,
    K_MOVE_TO = 4'd4,
    K_DRAW_BY = 4'd5,
    K_DRAW_TO = 4'd6,
    K_PUSH    = 4'd7,
    K_POP     = 4'd8,
    K_RESET   = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    R_EYE_DEPTH    = 2'd0,
    R_SCREEN_DEPTH = 2'd1,
    R_ORIGIN_X     = 2'd2,
    R_ORIGIN_Y     = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ROT, S_XLT, S_PROJ, S_EMIT, S_PUSH, S_POP_RD, S_POP_LD, S_IDENT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_ROT, OP_XLT, OP_PROJ, OP_EMIT, OP_PUSH, OP_POP_RD, OP_POP_LD, OP_IDENT
  } op_e;

  typedef struct packed {
    logic             take;
    op_e              op;
    logic [3:0]       kind;
    logic [CNT_W-1:0] cnt;
    logic             axis;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic out_busy;
  } stat_t;

  function automatic logic is_draw(logic [3:0] k);
    return (k == K_DRAW_BY) || (k == K_DRAW_TO);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/vector_turtle_perspective_engine.sv -----
// Top level of the vector turtle engine with perspective projection.
//
//  port group   dir  fields
//  s_axis       in   tuser: kind; tdata: dx, dy, dz, cos_value, sin_value
//  m_axis       out  tdata: x_start, y_start, x_end, y_end
//  cfg          in   0 eye_depth, 1 screen_depth, 2 origin_x, 3 origin_y
//
// Rotations, moves and draws run through one shared 33x19 multiplier and a radix-2
// divider that runs 16 steps for each screen coordinate; a draw may also wait for
// the output register. An ignored push or pop and an unused kind are only accepted.
// Reset is asynchronous, active low; the stack memory has no clearing pass.
// A draw result waits in the output register; new items are taken meanwhile.
`default_nettype none
`include "vector_turtle_perspective_engine_assert.svh"
module vector_turtle_perspective_engine (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // dx[31:0], dy[63:32], dz[95:64], cos_value[113:96], sin_value[131:114], zero pad
  input  wire logic [vtpe_pkg::IN_W-1:0]  s_axis_tdata,
  // kind[3:0]
  input  wire logic [3:0]                 s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // x_start[15:0], y_start[31:16], x_end[47:32], y_end[63:48]
  output logic [vtpe_pkg::OUT_W-1:0]      m_axis_tdata,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_addr_i,
  input  wire logic [vtpe_pkg::CFG_W-1:0] cfg_data_i
);
  import vtpe_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  vtpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vtpe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_tdata_i  (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_tdata_o (m_axis_tdata)
  );

  `VTPE_ASSERT_IMP(a_emit_free, cmd.op == OP_EMIT && is_draw(cmd.kind), !stat.out_busy, "overwrite")
  `VTPE_ASSERT_IMP(a_push_room, cmd.op == OP_PUSH, !stat.full, "push on a full stack")
  `VTPE_ASSERT_NXT(a_pop_load, cmd.op == OP_POP_RD, cmd.op == OP_POP_LD, "pop without load")
  `VTPE_ASSERT_IMP(a_level_sane, 1'b1, !(stat.full && stat.empty), "stack full and empty")

endmodule
`default_nettype wire

// ----- hw/rtl/vtpe_ctrl.sv -----
// Command sequencer of the vector turtle engine.
`default_nettype none
module vtpe_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [3:0]    in_kind_i,
  output logic               in_ready_o,
  input  vtpe_pkg::stat_t    stat_i,
  output vtpe_pkg::cmd_t     cmd_o
);
  import vtpe_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             axis_q, axis_d;
  logic [3:0]       kind_q, kind_d;

  // Hold state, step, axis and latched kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      axis_q  <= 1'b0;
      kind_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
      kind_q  <= kind_d;
    end
  end

  // Decode commands and advance the sequence
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    axis_d      = axis_q;
    kind_d      = kind_q;
    in_ready_o  = 1'b0;
    cmd_o.take  = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.kind  = kind_q;
    cmd_o.cnt   = cnt_q;
    cmd_o.axis  = axis_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
        axis_d     = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          kind_d     = in_kind_i;
          case (in_kind_i)
            K_ROTX, K_ROTY, K_ROTZ:                    state_d = S_ROT;
            K_MOVE_BY, K_MOVE_TO, K_DRAW_BY, K_DRAW_TO: state_d = S_XLT;
            K_PUSH:  state_d = stat_i.full  ? S_IDLE : S_PUSH;
            K_POP:   state_d = stat_i.empty ? S_IDLE : S_POP_RD;
            K_RESET: state_d = S_IDENT;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ROT: begin
        cmd_o.op = OP_ROT;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == ROT_LAST) state_d = S_IDLE;
      end
      S_XLT: begin
        cmd_o.op = OP_XLT;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == XLT_LAST) begin
          state_d = S_PROJ;
          cnt_d   = '0;
        end
      end
      S_PROJ: begin
        cmd_o.op = OP_PROJ;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == PROJ_LAST) begin
          cnt_d = '0;
          if (axis_q) state_d = S_EMIT;
          else        axis_d  = 1'b1;
        end
      end
      S_EMIT: begin
        // wait while a draw result would overwrite one not yet taken
        if (!(is_draw(kind_q) && stat_i.out_busy)) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      S_PUSH: begin
        cmd_o.op = OP_PUSH;
        state_d  = S_IDLE;
      end
      S_POP_RD: begin
        cmd_o.op = OP_POP_RD;
        state_d  = S_POP_LD;
      end
      S_POP_LD: begin
        cmd_o.op = OP_POP_LD;
        state_d  = S_IDLE;
      end
      S_IDENT: begin
        cmd_o.op = OP_IDENT;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/vtpe_dp.sv -----
// Datapath: turtle state, shared multiplier, divider, stack memory, output register.
`default_nettype none
module vtpe_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  vtpe_pkg::cmd_t                  cmd_i,
  input  wire logic [vtpe_pkg::IN_W-1:0]  in_tdata_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_addr_i,
  input  wire logic [vtpe_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                       out_ready_i,
  output vtpe_pkg::stat_t                 stat_o,
  output logic                            out_valid_o,
  output logic [vtpe_pkg::OUT_W-1:0]      out_tdata_o
);
  import vtpe_pkg::*;

  // Architectural state
  logic signed [ORI_W-1:0] ori_q [9];
  logic signed [POS_W-1:0] pos_q [3];
  logic signed [SCR_W-1:0] scr_q [2];
  logic [LVL_W-1:0]        lvl_q;
  logic signed [15:0]      eye_q, sd_q;
  logic [11:0]             ox_q, oy_q;
  logic                    out_valid_q;

  // Work registers
  logic signed [32:0]      v_q [3];
  logic signed [17:0]      c_q, s_q;
  logic signed [51:0]      prod_q, acc_q;
  logic signed [ORI_W-1:0] na_q;
  logic signed [SCR_W-1:0] nxy_q [2];
  logic [31:0]             rem_q, den_q;
  logic [15:0]             quo_q;
  logic                    sign_q, bad_q, nz_q, ovf_q;
  logic [OUT_W-1:0]        out_q;

  // Stack memory
  logic [ROW_W-1:0]        mem [STACK_DEPTH];
  logic [ROW_W-1:0]        rd_q, wr_row;

  // Operand selection
  logic [3:0]              j;
  logic [1:0]              rk, rm, xi, xm;
  logic [1:0]              row_a, row_b;
  logic [3:0]              ia, ib, ix;
  logic signed [32:0]      mul_a;
  logic signed [18:0]      mul_b;
  logic                    clr;
  logic signed [51:0]      acc_new, rnd;
  logic signed [52:0]      tsum;
  logic signed [ORI_W-1:0] rot_res;
  logic signed [POS_W-1:0] xlt_res;
  logic                    rel;

  // Divider set-up
  logic signed [31:0]      sd32, zc;
  logic signed [33:0]      den34;
  logic signed [47:0]      num48;
  logic [47:0]             mag;
  logic [32:0]             trial;
  logic                    ge;
  logic signed [SCR_W-1:0] qres;

  // Output sums
  logic signed [17:0]      sx0, sy0, sx1, sy1;
  logic [LVL_W-1:0]        lvl_m1;

  function automatic logic signed [ORI_W-1:0] sat18(logic signed [51:0] v);
    if (v > 52'sd131071)       return 18'sh1FFFF;
    else if (v < -52'sd131072) return 18'sh20000;
    else                       return v[ORI_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] sat32(logic signed [52:0] v);
    if (v > 53'sd2147483647)       return 32'sh7FFFFFFF;
    else if (v < -53'sd2147483648) return 32'sh80000000;
    else                           return v[POS_W-1:0];
  endfunction

  function automatic logic signed [SCR_W-1:0] sat16(logic signed [17:0] v);
    if (v > 18'sd32767)       return 16'sh7FFF;
    else if (v < -18'sd32768) return 16'sh8000;
    else                      return v[SCR_W-1:0];
  endfunction

  // Decode step into rows, columns and operands
  always_comb begin
    j  = cmd_i.cnt[4:1];
    rk = j[3:2];
    rm = j[1:0];
    case (j)
      4'd0: begin xi = 2'd0; xm = 2'd0; end
      4'd1: begin xi = 2'd0; xm = 2'd1; end
      4'd2: begin xi = 2'd0; xm = 2'd2; end
      4'd3: begin xi = 2'd1; xm = 2'd0; end
      4'd4: begin xi = 2'd1; xm = 2'd1; end
      4'd5: begin xi = 2'd1; xm = 2'd2; end
      4'd6: begin xi = 2'd2; xm = 2'd0; end
      4'd7: begin xi = 2'd2; xm = 2'd1; end
      default: begin xi = 2'd2; xm = 2'd2; end
    endcase
    case (cmd_i.kind)
      K_ROTX:  begin row_a = 2'd1; row_b = 2'd2; end
      K_ROTY:  begin row_a = 2'd0; row_b = 2'd2; end
      default: begin row_a = 2'd0; row_b = 2'd1; end
    endcase
    ia = 4'(row_a) * 4'd3 + 4'(rk);
    ib = 4'(row_b) * 4'd3 + 4'(rk);
    ix = 4'(xi) * 4'd3 + 4'(xm);
    case (cmd_i.op)
      OP_ROT: begin
        case (rm)
          2'd0:    begin mul_a = 33'(ori_q[ia]); mul_b = 19'(c_q);    end
          2'd1:    begin mul_a = 33'(ori_q[ib]); mul_b = -(19'(s_q)); end
          2'd2:    begin mul_a = 33'(ori_q[ia]); mul_b = 19'(s_q);    end
          default: begin mul_a = 33'(ori_q[ib]); mul_b = 19'(c_q);    end
        endcase
      end
      OP_XLT: begin
        mul_a = v_q[xm];
        mul_b = 19'(ori_q[ix]);
      end
      default: begin
        mul_a = 33'(pos_q[cmd_i.axis]);
        mul_b = -(19'(sd_q));
      end
    endcase
    clr     = (cmd_i.op == OP_ROT) ? !rm[0] : (xm == 2'd0);
    acc_new = (clr ? 52'sd0 : acc_q) + prod_q;
    rnd     = (acc_new + 52'sd32768) >>> 16;
    rot_res = sat18(rnd);
    rel     = (cmd_i.kind == K_MOVE_BY) || (cmd_i.kind == K_DRAW_BY);
    tsum    = 53'(rnd) + (rel ? 53'(pos_q[xi]) : 53'sd0);
    xlt_res = sat32(tsum);
  end

  // Projection set-up and divider step
  always_comb begin
    sd32  = $signed({sd_q, 16'h0000});
    zc    = (pos_q[2] < sd32) ? sd32 : pos_q[2];
    den34 = 34'(zc) - 34'($signed({eye_q, 16'h0000}));
    num48 = prod_q[47:0];
    mag   = num48[47] ? 48'(-num48) : 48'(num48);
    trial = {rem_q, quo_q[15]};
    ge    = trial >= {1'b0, den_q};
    if (bad_q)       qres = nz_q ? (sign_q ? 16'sh8000 : 16'sh7FFF) : 16'sh0000;
    else if (!sign_q) qres = (ovf_q || quo_q >= 16'd32767) ? 16'sh7FFF : $signed(quo_q);
    else             qres = (ovf_q || quo_q >= 16'd32768) ? 16'sh8000 : -$signed(quo_q);
  end

  // Pack a stack row and form output sums
  always_comb begin
    wr_row = '0;
    for (int n = 0; n < 9; n++) wr_row[n*ORI_W +: ORI_W] = ori_q[n];
    for (int n = 0; n < 3; n++) wr_row[9*ORI_W + n*POS_W +: POS_W] = pos_q[n];
    for (int n = 0; n < 2; n++) wr_row[9*ORI_W + 3*POS_W + n*SCR_W +: SCR_W] = scr_q[n];
    sx0    = $signed({6'b0, ox_q}) + 18'(scr_q[0]);
    sy0    = $signed({6'b0, oy_q}) + 18'(scr_q[1]);
    sx1    = $signed({6'b0, ox_q}) + 18'(nxy_q[0]);
    sy1    = $signed({6'b0, oy_q}) + 18'(nxy_q[1]);
    lvl_m1 = lvl_q - 1'b1;
  end

  // Update turtle state, stack level, configuration and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < 9; n++) ori_q[n] <= (n % 4 == 0) ? 18'sd65536 : 18'sd0;
      for (int n = 0; n < 3; n++) pos_q[n] <= '0;
      scr_q[0]    <= '0;
      scr_q[1]    <= '0;
      lvl_q       <= '0;
      eye_q       <= -16'sd2048;
      sd_q        <= -16'sd1024;
      ox_q        <= '0;
      oy_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          R_EYE_DEPTH:    eye_q <= $signed(cfg_data_i);
          R_SCREEN_DEPTH: sd_q  <= $signed(cfg_data_i);
          R_ORIGIN_X:     ox_q  <= cfg_data_i[11:0];
          R_ORIGIN_Y:     oy_q  <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      // raise valid on a draw result, drop it once taken
      if (cmd_i.op == OP_EMIT && is_draw(cmd_i.kind)) out_valid_q <= 1'b1;
      else if (out_ready_i)                           out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_ROT: begin
          if (cmd_i.cnt[0] && rm == 2'd3) begin
            ori_q[ia] <= na_q;
            ori_q[ib] <= rot_res;
          end
        end
        OP_XLT: begin
          if (cmd_i.cnt[0] && xm == 2'd2) pos_q[xi] <= xlt_res;
        end
        OP_EMIT: begin
          scr_q[0] <= nxy_q[0];
          scr_q[1] <= nxy_q[1];
        end
        OP_PUSH:   lvl_q <= lvl_q + 1'b1;
        OP_POP_RD: lvl_q <= lvl_m1;
        OP_POP_LD: begin
          for (int n = 0; n < 9; n++) ori_q[n] <= rd_q[n*ORI_W +: ORI_W];
          for (int n = 0; n < 3; n++) pos_q[n] <= rd_q[9*ORI_W + n*POS_W +: POS_W];
          for (int n = 0; n < 2; n++) scr_q[n] <= rd_q[9*ORI_W + 3*POS_W + n*SCR_W +: SCR_W];
        end
        OP_IDENT: begin
          for (int n = 0; n < 9; n++) ori_q[n] <= (n % 4 == 0) ? 18'sd65536 : 18'sd0;
          for (int n = 0; n < 3; n++) pos_q[n] <= '0;
        end
        default: ;
      endcase
    end
  end

  // Latch item, multiply, accumulate, divide, load output
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      v_q[0] <= 33'($signed(in_tdata_i[31:0]));
      v_q[1] <= -(33'($signed(in_tdata_i[63:32])));
      v_q[2] <= 33'($signed(in_tdata_i[95:64]));
      c_q    <= $signed(in_tdata_i[113:96]);
      s_q    <= $signed(in_tdata_i[131:114]);
    end
    if (!cmd_i.cnt[0]) prod_q <= mul_a * mul_b;
    if ((cmd_i.op == OP_ROT || cmd_i.op == OP_XLT) && cmd_i.cnt[0]) begin
      acc_q <= acc_new;
      if (cmd_i.op == OP_ROT && rm == 2'd1) na_q <= rot_res;
    end
    if (cmd_i.op == OP_PROJ) begin
      if (cmd_i.cnt == PROJ_LOAD) begin
        den_q  <= den34[31:0];
        bad_q  <= den34 <= 34'sd0;
        sign_q <= num48[47];
        nz_q   <= mag != 48'd0;
        ovf_q  <= {1'b0, mag[46:16]} >= den34[31:0];
        rem_q  <= {1'b0, mag[46:16]};
        quo_q  <= mag[15:0];
      end else if (cmd_i.cnt == PROJ_LAST) begin
        nxy_q[cmd_i.axis] <= qres;
      end else if (cmd_i.cnt != PROJ_MUL) begin
        rem_q <= ge ? 32'(trial - {1'b0, den_q}) : trial[31:0];
        quo_q <= {quo_q[14:0], ge};
      end
    end
    if (cmd_i.op == OP_EMIT && is_draw(cmd_i.kind)) begin
      out_q <= {sat16(sy1), sat16(sx1), sat16(sy0), sat16(sx0)};
    end
  end

  // Stack memory: one row per push, registered read on pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PUSH)   mem[lvl_q[ADDR_W-1:0]] <= wr_row;
    if (cmd_i.op == OP_POP_RD) rd_q <= mem[lvl_m1[ADDR_W-1:0]];
  end

  assign stat_o.full     = lvl_q == LVL_W'(STACK_DEPTH);
  assign stat_o.empty    = lvl_q == '0;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_tdata_o     = out_q;

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking testbench of the vector turtle perspective engine.
`timescale 1ns / 100ps
`default_nettype none

class line_scoreboard;
  // predictor state
  longint ori[9];
  longint pos[3];
  longint last_scr[2];
  longint sv_ori[127*9];
  longint sv_pos[127*3];
  longint sv_scr[127*2];
  int     level;
  longint eye, scr_d, org_x, org_y;
  logic [63:0] pending_lines[$];
  int     errors;
  int     lines_seen;

  function new();
    errors = 0;
    lines_seen = 0;
    level = 0;
    last_scr[0] = 0;
    last_scr[1] = 0;
    eye = -2048;
    scr_d = -1024;
    org_x = 0;
    org_y = 0;
    identity();
  endfunction

  function void identity();
    for (int i = 0; i < 9; i++) ori[i] = (i % 4 == 0) ? 65536 : 0;
    for (int i = 0; i < 3; i++) pos[i] = 0;
  endfunction

  function longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // arithmetic shift is a floor shift on longint
  function longint rnd16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function void set_reg(vtpe_pkg::reg_e idx, logic [15:0] v);
    case (idx)
      vtpe_pkg::R_EYE_DEPTH:    eye = longint'($signed(v));
      vtpe_pkg::R_SCREEN_DEPTH: scr_d = longint'($signed(v));
      vtpe_pkg::R_ORIGIN_X:     org_x = longint'(v[11:0]);
      vtpe_pkg::R_ORIGIN_Y:     org_y = longint'(v[11:0]);
      default: ;
    endcase
  endfunction

  function void spin(int a, int b, longint c, longint s);
    longint ra, rb;
    for (int k = 0; k < 3; k++) begin
      ra = ori[a*3+k];
      rb = ori[b*3+k];
      ori[a*3+k] = clamp(rnd16(c*ra - s*rb), -131072, 131071);
      ori[b*3+k] = clamp(rnd16(s*ra + c*rb), -131072, 131071);
    end
  endfunction

  function longint project(longint p, longint z);
    longint sc, num, den;
    sc = scr_d * 65536;
    if (z < sc) z = sc;
    den = z - eye * 65536;
    num = p * (-scr_d);
    if (den <= 0) return num > 0 ? 32767 : (num < 0 ? -32768 : 0);
    return clamp(num / den, -32768, 32767);
  endfunction

  // note one accepted command
  function void note_command(logic [3:0] kind, logic [135:0] d);
    longint c, s, v[3], t, nx, ny;
    logic [15:0] o[4];
    c = longint'($signed(d[113:96]));
    s = longint'($signed(d[131:114]));
    case (kind)
      vtpe_pkg::K_ROTX: spin(1, 2, c, s);
      vtpe_pkg::K_ROTY: spin(0, 2, c, s);
      vtpe_pkg::K_ROTZ: spin(0, 1, c, s);
      vtpe_pkg::K_MOVE_BY, vtpe_pkg::K_MOVE_TO, vtpe_pkg::K_DRAW_BY,
      vtpe_pkg::K_DRAW_TO: begin
        v[0] = longint'($signed(d[31:0]));
        v[1] = -longint'($signed(d[63:32]));
        v[2] = longint'($signed(d[95:64]));
        for (int i = 0; i < 3; i++) begin
          t = rnd16(v[0]*ori[i*3] + v[1]*ori[i*3+1] + v[2]*ori[i*3+2]);
          if (kind == vtpe_pkg::K_MOVE_BY || kind == vtpe_pkg::K_DRAW_BY) t += pos[i];
          pos[i] = clamp(t, -64'sd2147483648, 64'sd2147483647);
        end
        nx = project(pos[0], pos[2]);
        ny = project(pos[1], pos[2]);
        if (vtpe_pkg::is_draw(kind)) begin
          o[0] = 16'(clamp(org_x + last_scr[0], -32768, 32767));
          o[1] = 16'(clamp(org_y + last_scr[1], -32768, 32767));
          o[2] = 16'(clamp(org_x + nx, -32768, 32767));
          o[3] = 16'(clamp(org_y + ny, -32768, 32767));
          pending_lines.push_back({o[3], o[2], o[1], o[0]});
        end
        last_scr[0] = nx;
        last_scr[1] = ny;
      end
      vtpe_pkg::K_PUSH: if (level < 127) begin
        for (int i = 0; i < 9; i++) sv_ori[level*9+i] = ori[i];
        for (int i = 0; i < 3; i++) sv_pos[level*3+i] = pos[i];
        for (int i = 0; i < 2; i++) sv_scr[level*2+i] = last_scr[i];
        level++;
      end
      vtpe_pkg::K_POP: if (level > 0) begin
        level--;
        for (int i = 0; i < 9; i++) ori[i] = sv_ori[level*9+i];
        for (int i = 0; i < 3; i++) pos[i] = sv_pos[level*3+i];
        for (int i = 0; i < 2; i++) last_scr[i] = sv_scr[level*2+i];
      end
      vtpe_pkg::K_RESET: identity();
      default: ;
    endcase
  endfunction

  task report(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    if (errors <= 30) $display("line %0d: %s got %0d want %0d", lines_seen, what,
                               $signed(got), $signed(want));
  endtask

  // check one accepted line
  task check_line(logic [63:0] got);
    logic [63:0] want;
    string names[4];
    names = '{"x_start", "y_start", "x_end", "y_end"};
    if (pending_lines.size() == 0) begin
      report("unexpected line, x_start", got[15:0], 16'd0);
    end else begin
      want = pending_lines.pop_front();
      for (int f = 0; f < 4; f++)
        if (got[f*16 +: 16] !== want[f*16 +: 16])
          report(names[f], got[f*16 +: 16], want[f*16 +: 16]);
    end
    lines_seen++;
  endtask
endclass

module tb;
  import vtpe_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic [3:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_addr_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  line_scoreboard sb = new();
  int  hold_off = 0;
  int  cmds_sent = 0;
  int  stall_mode = 0;

  vector_turtle_perspective_engine dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver: own stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    if (m_axis_tvalid && m_axis_tready) sb.check_line(m_axis_tdata);
  end

  task write_reg(reg_e idx, logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= v;
    sb.set_reg(idx, v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // offer one item and hold it until taken; gaps come from the caller
  task send_cmd(logic [3:0] kind, logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                logic [17:0] cv, logic [17:0] sv);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {4'b0, sv, cv, dz, dy, dx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_command(kind, s_axis_tdata);
    cmds_sent++;
  endtask

  task idle_gap(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // wait for all lines, then for the longest command to drain
  task drain();
    idle_gap(1);
    while (sb.pending_lines.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function logic [31:0] rnd_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'h7fffffff ^ {31'b0, $urandom_range(0, 1)};
      default: return {{12{1'b0}}, 20'($urandom())} - 32'h80000;
    endcase
  endfunction

  function logic [17:0] rnd_trig();
    case ($urandom_range(0, 3))
      0: return 18'($urandom_range(0, 131072)) - 18'd65536;
      1: return 18'($urandom());
      default: return $urandom_range(0, 1) ? 18'h10000 : 18'h30000;
    endcase
  endfunction

  task random_cmd();
    int r;
    logic [3:0] k;
    logic [17:0] c, s;
    real a;
    r = $urandom_range(0, 99);
    if (r < 20) k = 4'($urandom_range(0, 2));
    else if (r < 35) k = $urandom_range(0, 1) ? K_MOVE_BY : K_MOVE_TO;
    else if (r < 70) k = $urandom_range(0, 1) ? K_DRAW_BY : K_DRAW_TO;
    else if (r < 80) k = K_PUSH;
    else if (r < 90) k = K_POP;
    else if (r < 95) k = K_RESET;
    else k = 4'($urandom_range(10, 15));
    // mostly proper rotations, sometimes raw values
    if ($urandom_range(0, 3) != 0) begin
      a = $urandom_range(0, 6283) / 1000.0;
      c = 18'($rtoi($cos(a) * 65536.0));
      s = 18'($rtoi($sin(a) * 65536.0));
    end else begin
      c = rnd_trig();
      s = rnd_trig();
    end
    send_cmd(k, rnd_coord(), rnd_coord(), rnd_coord(), c, s);
    if ($urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 20));
  endtask

  initial begin
    #10_000_000;
    $display("timeout after %0d items", cmds_sent);
    $display("vector_turtle_perspective_engine: mismatch");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every kind, field extremes, clamps and stack edges
    send_cmd(K_POP, 0, 0, 0, 0, 0);
    send_cmd(K_DRAW_TO, 32'h00010000, 32'h00020000, 32'h00030000, 0, 0);
    send_cmd(K_DRAW_BY, 32'h7fffffff, 32'h80000000, 32'h80000000, 0, 0);
    send_cmd(K_DRAW_TO, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 0);
    send_cmd(K_ROTX, 0, 0, 0, 18'h10000, 18'h30000);
    send_cmd(K_ROTY, 0, 0, 0, 18'h3ffff, 18'h1ffff);
    send_cmd(K_ROTZ, 0, 0, 0, 18'h20000, 18'h10000);
    send_cmd(K_PUSH, 0, 0, 0, 0, 0);
    send_cmd(K_MOVE_BY, 32'hffffffff, 32'h1, 32'h10000, 0, 0);
    send_cmd(K_MOVE_TO, 32'h100000, 32'h200000, 32'hf8000000, 0, 0);
    send_cmd(K_DRAW_BY, 0, 0, 0, 0, 0);
    send_cmd(K_POP, 0, 0, 0, 0, 0);
    send_cmd(K_RESET, 0, 0, 0, 0, 0);
    send_cmd(4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 18'h3ffff, 18'h3ffff);
    send_cmd(K_DRAW_TO, 0, 0, 0, 0, 0);
    for (int i = 0; i < 128; i++) send_cmd(K_PUSH, 0, 0, 0, 0, 0);
    send_cmd(K_DRAW_TO, 32'h40000000, 32'hc0000000, 32'h0, 0, 0);
    for (int i = 0; i < 128; i++) send_cmd(K_POP, 0, 0, 0, 0, 0);
    drain();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      stall_mode = ph % 3;
      case (ph)
        0: begin
          write_reg(R_EYE_DEPTH, 16'h8000); write_reg(R_SCREEN_DEPTH, 16'h7fff);
          write_reg(R_ORIGIN_X, 16'h0fff); write_reg(R_ORIGIN_Y, 16'h0fff);
        end
        1: begin
          write_reg(R_EYE_DEPTH, 16'h7fff); write_reg(R_SCREEN_DEPTH, 16'h8000);
          write_reg(R_ORIGIN_X, 16'h0); write_reg(R_ORIGIN_Y, 16'h0);
        end
        2: begin
          write_reg(R_EYE_DEPTH, -16'sd2048); write_reg(R_SCREEN_DEPTH, -16'sd1024);
          write_reg(R_ORIGIN_X, 16'd512); write_reg(R_ORIGIN_Y, 16'd384);
        end
        default: begin
          write_reg(R_EYE_DEPTH, 16'($urandom())); write_reg(R_SCREEN_DEPTH, 16'($urandom()));
          write_reg(R_ORIGIN_X, 16'($urandom())); write_reg(R_ORIGIN_Y, 16'($urandom()));
        end
      endcase
      if (ph == 3) hold_off = 3000;
      for (int n = 0; n < 180; n++) random_cmd();
      drain();
    end

    $display("sent %0d commands, checked %0d lines over 8 register settings",
             cmds_sent, sb.lines_seen);
    $display("stack pushes and pops through full and empty, long output stall included");
    if (sb.errors == 0 && sb.pending_lines.size() == 0)
      $display("vector_turtle_perspective_engine: match");
    else
      $display("vector_turtle_perspective_engine: mismatch");
    $finish;
  end
endmodule

`default_nettype wire
